### src/abpc_pkg.sv
// ----------------------------------------------------------------------------
// abpc_pkg: shared types and constants for the box pair contact pipeline
// Face codes in corner order and the width of the contact point fields.
// ----------------------------------------------------------------------------
package abpc_pkg;

  localparam int OUT_WIDTH = 33;
  localparam int NUM_CORNERS = 4;

  typedef enum logic [1:0] {
    FACE_BOTTOM,
    FACE_RIGHT,
    FACE_TOP,
    FACE_LEFT
  } face_t;

endpackage

### src/aabb_pair_contact_points.sv
// ----------------------------------------------------------------------------
// aabb_pair_contact_points: corner-test contact points for two 2D boxes
// Takes one pair of axis-aligned boxes (centers Q15.16, half extents UQ14.16)
// per request, reports whether a corner of one box lies in or on the other,
// and on a hit gives the contact points on the face of least penetration.
//
// Usage:
//   - Request channel: drive the eight box fields and raise start; the
//     request is taken at a rising edge with start high and busy low.
//   - busy is high only while rst is high, so a request can be taken in
//     every cycle.
//   - Result channel: done is high for exactly one cycle together with hit
//     and the four contact coordinates. A miss gives zero coordinates.
//   - Throughput: one request per cycle; the five register stages (corners,
//     edge differences, deepest corner per face, least face per box, final
//     pick and contact point) each hold a different request.
//   - Reset: synchronous rst empties the pipeline; requests in flight are
//     dropped and no result is shown for them.
//   - The receiver takes each result in its done cycle and cannot stall.
// ----------------------------------------------------------------------------
module aabb_pair_contact_points #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [30:0]                  first_center_x,
  input  logic signed [30:0]                  first_center_y,
  input  logic        [29:0]                  first_half_width,
  input  logic        [29:0]                  first_half_height,
  input  logic signed [30:0]                  second_center_x,
  input  logic signed [30:0]                  second_center_y,
  input  logic        [29:0]                  second_half_width,
  input  logic        [29:0]                  second_half_height,
  output logic                                done,
  output logic                                hit,
  output logic signed [abpc_pkg::OUT_WIDTH-1:0] first_in_second_x,
  output logic signed [abpc_pkg::OUT_WIDTH-1:0] first_in_second_y,
  output logic signed [abpc_pkg::OUT_WIDTH-1:0] second_in_first_x,
  output logic signed [abpc_pkg::OUT_WIDTH-1:0] second_in_first_y
);

  import abpc_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int DW = COORD_WIDTH + 1;
  localparam int QW = COORD_WIDTH + 2;
  localparam int EW = (COORD_WIDTH > 32) ? COORD_WIDTH : 32;
  localparam int XW = (QW > OUT_WIDTH) ? QW : OUT_WIDTH;
  localparam int LATENCY = 5;

  function automatic logic signed [CW-1:0] wrap_sum(
    input logic signed [30:0] c,
    input logic        [29:0] h,
    input logic               neg
  );
    logic signed [EW-1:0] ce;
    logic signed [EW-1:0] he;
    logic signed [EW-1:0] s;
    ce = EW'(c);
    he = EW'(signed'({1'b0, h}));
    s  = neg ? (ce - he) : (ce + he);
    return s[CW-1:0];
  endfunction

  function automatic logic signed [DW-1:0] face_depth(
    input face_t                f,
    input logic signed [CW-1:0] fl,
    input logic signed [CW-1:0] fr,
    input logic signed [CW-1:0] flo,
    input logic signed [CW-1:0] fhi,
    input logic signed [CW-1:0] px,
    input logic signed [CW-1:0] py
  );
    logic signed [DW-1:0] d;
    unique case (f)
      FACE_BOTTOM: d = DW'(py) - DW'(flo);
      FACE_RIGHT:  d = DW'(fr) - DW'(px);
      FACE_TOP:    d = DW'(fhi) - DW'(py);
      FACE_LEFT:   d = DW'(px) - DW'(fl);
      default:     d = '0;
    endcase
    return d;
  endfunction

  function automatic logic [OUT_WIDTH-1:0] to_out(input logic signed [QW-1:0] v);
    logic signed [XW-1:0] t;
    t = XW'(v);
    return t[OUT_WIDTH-1:0];
  endfunction

  // stage 1: corners
  logic                 s1_valid;
  logic signed [CW-1:0] s1_x [2][NUM_CORNERS];
  logic signed [CW-1:0] s1_y [2][NUM_CORNERS];
  logic signed [CW-1:0] lft  [2];
  logic signed [CW-1:0] rgt  [2];
  logic signed [CW-1:0] bot  [2];
  logic signed [CW-1:0] top  [2];

  // stage 2: edge differences
  logic                 s2_valid;
  logic signed [CW-1:0] s2_x   [2][NUM_CORNERS];
  logic signed [CW-1:0] s2_y   [2][NUM_CORNERS];
  logic signed [DW-1:0] s2_dep [2][4][NUM_CORNERS];
  logic signed [DW-1:0] dep_next [2][4][NUM_CORNERS];

  // stage 3: deepest corner per face
  logic                 s3_valid;
  logic                 s3_hit;
  logic        [CW-1:0] s3_deep [2][4];
  logic signed [CW-1:0] s3_px   [2][4];
  logic signed [CW-1:0] s3_py   [2][4];
  logic        [CW-1:0] deep_next [2][4];
  logic signed [CW-1:0] px_next   [2][4];
  logic signed [CW-1:0] py_next   [2][4];
  logic                 hit_next;

  // stage 4: least face per box
  logic                 s4_valid;
  logic                 s4_hit;
  logic        [CW-1:0] s4_sep  [2];
  logic signed [CW-1:0] s4_px   [2];
  logic signed [CW-1:0] s4_py   [2];
  face_t                s4_face [2];
  logic        [CW-1:0] sep_next  [2];
  logic signed [CW-1:0] spx_next  [2];
  logic signed [CW-1:0] spy_next  [2];
  face_t                face_next [2];

  // stage 5: final pick
  logic                 pick_second;
  logic        [CW-1:0] win_sep;
  logic signed [CW-1:0] win_px;
  logic signed [CW-1:0] win_py;
  face_t                win_face;
  logic signed [QW-1:0] p_x;
  logic signed [QW-1:0] p_y;
  logic signed [QW-1:0] q_x;
  logic signed [QW-1:0] q_y;
  logic signed [QW-1:0] sep_ext;

  assign busy = rst;

  always_comb begin
    lft[0] = wrap_sum(first_center_x, first_half_width, 1'b1);
    rgt[0] = wrap_sum(first_center_x, first_half_width, 1'b0);
    bot[0] = wrap_sum(first_center_y, first_half_height, 1'b1);
    top[0] = wrap_sum(first_center_y, first_half_height, 1'b0);
    lft[1] = wrap_sum(second_center_x, second_half_width, 1'b1);
    rgt[1] = wrap_sum(second_center_x, second_half_width, 1'b0);
    bot[1] = wrap_sum(second_center_y, second_half_height, 1'b1);
    top[1] = wrap_sum(second_center_y, second_half_height, 1'b0);
  end

  always_ff @(posedge clk) begin
    for (int b = 0; b < 2; b++) begin
      s1_x[b][0] <= lft[b];
      s1_x[b][1] <= rgt[b];
      s1_x[b][2] <= rgt[b];
      s1_x[b][3] <= lft[b];
      s1_y[b][0] <= bot[b];
      s1_y[b][1] <= bot[b];
      s1_y[b][2] <= top[b];
      s1_y[b][3] <= top[b];
    end
  end

  always_comb begin
    for (int p = 0; p < 2; p++) begin
      for (int f = 0; f < 4; f++) begin
        for (int j = 0; j < NUM_CORNERS; j++) begin
          dep_next[p][f][j] = face_depth(face_t'(f), s1_x[p][0], s1_x[p][1],
                                         s1_y[p][0], s1_y[p][2],
                                         s1_x[p ^ 1][j], s1_y[p ^ 1][j]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    s2_x   <= s1_x;
    s2_y   <= s1_y;
    s2_dep <= dep_next;
  end

  always_comb begin
    logic corner_in;
    corner_in = 1'b0;
    hit_next  = 1'b0;
    for (int p = 0; p < 2; p++) begin
      for (int f = 0; f < 4; f++) begin
        deep_next[p][f] = '0;
        px_next[p][f]   = '0;
        py_next[p][f]   = '0;
        for (int j = 0; j < NUM_CORNERS; j++) begin
          if (s2_dep[p][f][j] > signed'({1'b0, deep_next[p][f]})) begin
            deep_next[p][f] = s2_dep[p][f][j][CW-1:0];
            px_next[p][f]   = s2_x[p ^ 1][j];
            py_next[p][f]   = s2_y[p ^ 1][j];
          end
        end
      end
      for (int j = 0; j < NUM_CORNERS; j++) begin
        corner_in = 1'b1;
        for (int f = 0; f < 4; f++) begin
          if (s2_dep[p][f][j] < 0) begin
            corner_in = 1'b0;
          end
        end
        if (corner_in) begin
          hit_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    s3_hit  <= hit_next;
    s3_deep <= deep_next;
    s3_px   <= px_next;
    s3_py   <= py_next;
  end

  always_comb begin
    for (int p = 0; p < 2; p++) begin
      sep_next[p]  = s3_deep[p][0];
      spx_next[p]  = s3_px[p][0];
      spy_next[p]  = s3_py[p][0];
      face_next[p] = FACE_BOTTOM;
      for (int f = 1; f < 4; f++) begin
        if (s3_deep[p][f] < sep_next[p]) begin
          sep_next[p]  = s3_deep[p][f];
          spx_next[p]  = s3_px[p][f];
          spy_next[p]  = s3_py[p][f];
          face_next[p] = face_t'(f);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    s4_hit  <= s3_hit;
    s4_sep  <= sep_next;
    s4_px   <= spx_next;
    s4_py   <= spy_next;
    s4_face <= face_next;
  end

  always_comb begin
    pick_second = s4_sep[1] < s4_sep[0];
    win_sep     = pick_second ? s4_sep[1]  : s4_sep[0];
    win_px      = pick_second ? s4_px[1]   : s4_px[0];
    win_py      = pick_second ? s4_py[1]   : s4_py[0];
    win_face    = pick_second ? s4_face[1] : s4_face[0];
    p_x         = QW'(win_px);
    p_y         = QW'(win_py);
    sep_ext     = QW'(signed'({1'b0, win_sep}));
    q_x         = p_x;
    q_y         = p_y;
    unique case (win_face)
      FACE_BOTTOM: q_y = p_y - sep_ext;
      FACE_RIGHT:  q_x = p_x + sep_ext;
      FACE_TOP:    q_y = p_y + sep_ext;
      FACE_LEFT:   q_x = p_x - sep_ext;
      default:     q_x = p_x;
    endcase
  end

  always_ff @(posedge clk) begin
    hit <= s4_hit;
    if (!s4_hit) begin
      first_in_second_x <= '0;
      first_in_second_y <= '0;
      second_in_first_x <= '0;
      second_in_first_y <= '0;
    end else if (pick_second) begin
      first_in_second_x <= to_out(p_x);
      first_in_second_y <= to_out(p_y);
      second_in_first_x <= to_out(q_x);
      second_in_first_y <= to_out(q_y);
    end else begin
      first_in_second_x <= to_out(q_x);
      first_in_second_y <= to_out(q_y);
      second_in_first_x <= to_out(p_x);
      second_in_first_y <= to_out(p_y);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      done     <= s4_valid;
    end
  end

  a_done_follows_request: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without a matching request");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    done && !hit |-> first_in_second_x == 0 && first_in_second_y == 0 &&
                     second_in_first_x == 0 && second_in_first_y == 0)
    else $error("miss with nonzero contact points");

  a_hit_shares_axis: assert property (@(posedge clk) disable iff (rst)
    done && hit |-> first_in_second_x == second_in_first_x ||
                    first_in_second_y == second_in_first_y)
    else $error("contact points differ on both axes");

  a_valid_chain: assert property (@(posedge clk) disable iff (rst)
    s4_valid |=> done)
    else $error("pipeline dropped a request");

endmodule

### bench/tb_aabb_pair_contact_points.sv
// ----------------------------------------------------------------------------
// tb_aabb_pair_contact_points: self-checking bench for the box pair contact block
// A queue of box pair requests, directed extremes first and then random pairs
// shaped to overlap, touch, cross, nest or miss, is sent in bursts with random
// gaps. Each accepted request is run through a local contact-point predictor,
// and every done strobe is checked field by field against the oldest entry.
// ----------------------------------------------------------------------------
module tb_aabb_pair_contact_points;
  import abpc_pkg::*;

  localparam int COORD_W = 32;
  localparam int LATENCY = 5;
  localparam int IDLE_LIMIT = 2000;
  localparam int N_RANDOM = 1430;
  localparam longint EXT_MAX = 64'sd536870912;
  localparam longint CTR_MAX = 64'sd1073741823;
  localparam longint CTR_MIN = -64'sd1073741824;
  localparam longint U = 64'sd65536;

  typedef struct {
    logic signed [30:0] fcx;
    logic signed [30:0] fcy;
    logic        [29:0] fhw;
    logic        [29:0] fhh;
    logic signed [30:0] scx;
    logic signed [30:0] scy;
    logic        [29:0] shw;
    logic        [29:0] shh;
  } box_pair_t;

  typedef struct {
    logic                         hit;
    logic signed [OUT_WIDTH-1:0] fisx;
    logic signed [OUT_WIDTH-1:0] fisy;
    logic signed [OUT_WIDTH-1:0] sifx;
    logic signed [OUT_WIDTH-1:0] sify;
  } contact_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [30:0] first_center_x = '0;
  logic signed [30:0] first_center_y = '0;
  logic        [29:0] first_half_width = 30'd1;
  logic        [29:0] first_half_height = 30'd1;
  logic signed [30:0] second_center_x = '0;
  logic signed [30:0] second_center_y = '0;
  logic        [29:0] second_half_width = 30'd1;
  logic        [29:0] second_half_height = 30'd1;
  logic done;
  logic hit;
  logic signed [OUT_WIDTH-1:0] first_in_second_x;
  logic signed [OUT_WIDTH-1:0] first_in_second_y;
  logic signed [OUT_WIDTH-1:0] second_in_first_x;
  logic signed [OUT_WIDTH-1:0] second_in_first_y;

  box_pair_t pending_pairs[$];
  contact_t expected_contacts[$];
  box_pair_t cur_pair;
  contact_t want;
  int errors = 0;
  int sent_count = 0;
  int n_directed = 0;
  int burst_left = 8;
  int gap_left = 0;
  bit hold_drain = 1'b0;
  int idle_cycles = 0;

  aabb_pair_contact_points #(
    .COORD_WIDTH(COORD_W)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .first_center_x(first_center_x),
    .first_center_y(first_center_y),
    .first_half_width(first_half_width),
    .first_half_height(first_half_height),
    .second_center_x(second_center_x),
    .second_center_y(second_center_y),
    .second_half_width(second_half_width),
    .second_half_height(second_half_height),
    .done(done),
    .hit(hit),
    .first_in_second_x(first_in_second_x),
    .first_in_second_y(first_in_second_y),
    .second_in_first_x(second_in_first_x),
    .second_in_first_y(second_in_first_y)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint wrap_coord(longint v);
    logic signed [COORD_W-1:0] t;
    t = v[COORD_W-1:0];
    return longint'(t);
  endfunction

  function automatic longint face_depth(face_t f, longint l, longint r, longint lo,
                                        longint hi, longint x, longint y);
    case (f)
      FACE_BOTTOM: return y - lo;
      FACE_RIGHT:  return r - x;
      FACE_TOP:    return hi - y;
      default:     return x - l;
    endcase
  endfunction

  function automatic contact_t predict_contact(box_pair_t p);
    longint l[2], r[2], lo[2], hi[2];
    longint x, y, d, deep, dx, dy, best, bx, by, qx, qy;
    int fb, pb, j, k;
    bit have, owner_first, in_box, hit_any;
    face_t best_f;
    contact_t c;
    l[0] = wrap_coord(longint'(p.fcx) - longint'(p.fhw));
    r[0] = wrap_coord(longint'(p.fcx) + longint'(p.fhw));
    lo[0] = wrap_coord(longint'(p.fcy) - longint'(p.fhh));
    hi[0] = wrap_coord(longint'(p.fcy) + longint'(p.fhh));
    l[1] = wrap_coord(longint'(p.scx) - longint'(p.shw));
    r[1] = wrap_coord(longint'(p.scx) + longint'(p.shw));
    lo[1] = wrap_coord(longint'(p.scy) - longint'(p.shh));
    hi[1] = wrap_coord(longint'(p.scy) + longint'(p.shh));
    c.hit = 1'b0;
    c.fisx = '0;
    c.fisy = '0;
    c.sifx = '0;
    c.sify = '0;
    hit_any = 1'b0;
    for (pb = 0; pb < 2; pb++) begin
      fb = 1 - pb;
      for (j = 0; j < NUM_CORNERS; j++) begin
        x = (j == 0 || j == 3) ? l[pb] : r[pb];
        y = (j < 2) ? lo[pb] : hi[pb];
        in_box = 1'b1;
        for (k = 0; k < 4; k++)
          if (face_depth(face_t'(k), l[fb], r[fb], lo[fb], hi[fb], x, y) < 0) in_box = 1'b0;
        if (in_box) hit_any = 1'b1;
      end
    end
    if (!hit_any) return c;
    have = 1'b0;
    best = 0;
    bx = 0;
    by = 0;
    best_f = FACE_BOTTOM;
    owner_first = 1'b1;
    for (fb = 0; fb < 2; fb++) begin
      pb = 1 - fb;
      for (k = 0; k < 4; k++) begin
        deep = 0;
        dx = 0;
        dy = 0;
        for (j = 0; j < NUM_CORNERS; j++) begin
          x = (j == 0 || j == 3) ? l[pb] : r[pb];
          y = (j < 2) ? lo[pb] : hi[pb];
          d = face_depth(face_t'(k), l[fb], r[fb], lo[fb], hi[fb], x, y);
          if (d > deep) begin
            deep = d;
            dx = x;
            dy = y;
          end
        end
        if (!have || deep < best) begin
          have = 1'b1;
          best = deep;
          bx = dx;
          by = dy;
          best_f = face_t'(k);
          owner_first = (fb == 0);
        end
      end
    end
    qx = bx;
    qy = by;
    case (best_f)
      FACE_BOTTOM: qy = qy - best;
      FACE_RIGHT:  qx = qx + best;
      FACE_TOP:    qy = qy + best;
      default:     qx = qx - best;
    endcase
    c.hit = 1'b1;
    if (owner_first) begin
      c.fisx = qx[OUT_WIDTH-1:0];
      c.fisy = qy[OUT_WIDTH-1:0];
      c.sifx = bx[OUT_WIDTH-1:0];
      c.sify = by[OUT_WIDTH-1:0];
    end else begin
      c.fisx = bx[OUT_WIDTH-1:0];
      c.fisy = by[OUT_WIDTH-1:0];
      c.sifx = qx[OUT_WIDTH-1:0];
      c.sify = qy[OUT_WIDTH-1:0];
    end
    return c;
  endfunction

  function automatic logic [29:0] fit_ext(longint v);
    longint t;
    t = (v < 1) ? 1 : ((v > EXT_MAX) ? EXT_MAX : v);
    return t[29:0];
  endfunction

  function automatic box_pair_t make_pair(longint ax, longint ay, longint aw, longint ah,
                                          longint bx, longint by, longint bw, longint bh);
    box_pair_t p;
    p.fcx = ax[30:0];
    p.fcy = ay[30:0];
    p.fhw = fit_ext(aw);
    p.fhh = fit_ext(ah);
    p.scx = bx[30:0];
    p.scy = by[30:0];
    p.shw = fit_ext(bw);
    p.shh = fit_ext(bh);
    return p;
  endfunction

  function automatic box_pair_t rand_pair();
    int unsigned s, hw1, hh1, hw2, hh2, rx, ry;
    longint cx, cy, dx, dy, off;
    logic signed [30:0] t;
    int kind;
    kind = $urandom_range(0, 9);
    s = $urandom_range(2, 27);
    hw1 = $urandom_range(1, 32'd1 << s);
    hh1 = $urandom_range(1, 32'd1 << s);
    hw2 = $urandom_range(1, 32'd1 << s);
    hh2 = $urandom_range(1, 32'd1 << s);
    t = 31'($urandom());
    cx = t;
    t = 31'($urandom());
    cy = t;
    case (kind)
      0, 1, 2, 3, 4: begin
        rx = hw1 + hw2;
        ry = hh1 + hh2;
        dx = longint'($urandom_range(0, 2 * rx)) - rx;
        dy = longint'($urandom_range(0, 2 * ry)) - ry;
        return make_pair(cx, cy, hw1, hh1, cx + dx, cy + dy, hw2, hh2);
      end
      5: begin
        dx = longint'($urandom_range(0, 2 * (hw1 - 1))) - (hw1 - 1);
        dy = longint'($urandom_range(0, 2 * (hh2 - 1))) - (hh2 - 1);
        return make_pair(cx, cy, longint'(hw1) + hw2, hh1, cx + dx, cy + dy, hw2,
                         longint'(hh1) + hh2);
      end
      6: begin
        if ($urandom_range(0, 1) == 1) begin
          off = longint'(hw1) + hw2;
          ry = hh1 + hh2;
          dy = longint'($urandom_range(0, 2 * ry)) - ry;
          if ($urandom_range(0, 1) == 1) off = -off;
          return make_pair(cx, cy, hw1, hh1, cx + off, cy + dy, hw2, hh2);
        end else begin
          off = longint'(hh1) + hh2;
          rx = hw1 + hw2;
          dx = longint'($urandom_range(0, 2 * rx)) - rx;
          if ($urandom_range(0, 1) == 1) off = -off;
          return make_pair(cx, cy, hw1, hh1, cx + dx, cy + off, hw2, hh2);
        end
      end
      7: begin
        hw2 = $urandom_range(1, hw1);
        hh2 = $urandom_range(1, hh1);
        rx = hw1 - hw2;
        ry = hh1 - hh2;
        dx = longint'($urandom_range(0, 2 * rx)) - rx;
        dy = longint'($urandom_range(0, 2 * ry)) - ry;
        if ($urandom_range(0, 1) == 1)
          return make_pair(cx, cy, hw1, hh1, cx + dx, cy + dy, hw2, hh2);
        return make_pair(cx + dx, cy + dy, hw2, hh2, cx, cy, hw1, hh1);
      end
      8: begin
        if ($urandom_range(0, 1) == 1) return make_pair(cx, cy, hw1, hh1, cx, cy, hw1, hh1);
        return make_pair(cx, cy, hw1, hh1, cx, cy, hw2, hh2);
      end
      default: begin
        t = 31'($urandom());
        dx = t;
        t = 31'($urandom());
        dy = t;
        return make_pair(cx, cy, $urandom_range(1, EXT_MAX), $urandom_range(1, EXT_MAX),
                         dx, dy, $urandom_range(1, EXT_MAX), $urandom_range(1, EXT_MAX));
      end
    endcase
  endfunction

  task automatic check_field(string name, logic signed [OUT_WIDTH-1:0] exp_v,
                             logic signed [OUT_WIDTH-1:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_contacts.push_back(predict_contact(cur_pair));
        sent_count++;
        if (sent_count == n_directed || sent_count == 600 || sent_count == 1100)
          hold_drain = 1'b1;
      end
      if (hold_drain && expected_contacts.size() == 0) hold_drain = 1'b0;
      if (start && busy) begin
        start <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (hold_drain || pending_pairs.size() == 0) begin
        start <= 1'b0;
      end else begin
        cur_pair = pending_pairs.pop_front();
        start <= 1'b1;
        first_center_x <= cur_pair.fcx;
        first_center_y <= cur_pair.fcy;
        first_half_width <= cur_pair.fhw;
        first_half_height <= cur_pair.fhh;
        second_center_x <= cur_pair.scx;
        second_center_y <= cur_pair.scy;
        second_half_width <= cur_pair.shw;
        second_half_height <= cur_pair.shh;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_contacts.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none, actual hit %0d", $time, hit);
      end else begin
        want = expected_contacts.pop_front();
        check_field("hit", {{(OUT_WIDTH-1){1'b0}}, want.hit}, {{(OUT_WIDTH-1){1'b0}}, hit});
        check_field("first_in_second_x", want.fisx, first_in_second_x);
        check_field("first_in_second_y", want.fisy, first_in_second_y);
        check_field("second_in_first_x", want.sifx, second_in_first_x);
        check_field("second_in_first_y", want.sify, second_in_first_y);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t no progress for %0d cycles", $time, IDLE_LIMIT);
      $display("** aabb_pair_contact_points: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    pending_pairs.push_back(make_pair(0, 0, U, U, 0, 0, U, U));
    pending_pairs.push_back(make_pair(0, 0, EXT_MAX, EXT_MAX, 0, 0, EXT_MAX, EXT_MAX));
    pending_pairs.push_back(make_pair(CTR_MAX, CTR_MAX, EXT_MAX, EXT_MAX, CTR_MAX, CTR_MAX, 1, 1));
    pending_pairs.push_back(make_pair(CTR_MIN, CTR_MIN, EXT_MAX, EXT_MAX, CTR_MIN + EXT_MAX,
                                      CTR_MIN + EXT_MAX, EXT_MAX, EXT_MAX));
    pending_pairs.push_back(make_pair(CTR_MAX, CTR_MIN, 1, 1, CTR_MIN, CTR_MAX, 1, 1));
    pending_pairs.push_back(make_pair(0, 0, 4 * U, U, 0, 0, U, 4 * U));
    pending_pairs.push_back(make_pair(0, 0, 2 * U, 2 * U, 3 * U, 0, 2 * U, 2 * U));
    pending_pairs.push_back(make_pair(0, 0, 2 * U, 2 * U, -3 * U, 0, 2 * U, 2 * U));
    pending_pairs.push_back(make_pair(0, 0, 2 * U, 2 * U, 0, 3 * U, 2 * U, 2 * U));
    pending_pairs.push_back(make_pair(0, 0, 2 * U, 2 * U, 0, -3 * U, 2 * U, 2 * U));
    pending_pairs.push_back(make_pair(0, 0, U, U, 2 * U, 0, U, U));
    pending_pairs.push_back(make_pair(0, 0, U, U, 2 * U, 2 * U, U, U));
    pending_pairs.push_back(make_pair(0, 0, 8 * U, 8 * U, U, -U, U, U));
    pending_pairs.push_back(make_pair(U, U, 1, 1, 0, 0, 8 * U, 8 * U));
    pending_pairs.push_back(make_pair(5, -7, 1, 1, 5, -7, 1, 1));
    pending_pairs.push_back(make_pair(0, 0, 1, 1, 3, 0, 1, 1));
    pending_pairs.push_back(make_pair(-1, 64'sh2AAAAAAA, 64'sh1FFFFFFF, 64'sh15555555,
                                      64'sh15555555, -1, 64'sh0AAAAAAA, 64'sh1FFFFFFF));
    pending_pairs.push_back(make_pair(CTR_MIN, CTR_MAX, EXT_MAX, EXT_MAX, CTR_MIN + EXT_MAX,
                                      CTR_MAX - EXT_MAX, EXT_MAX, EXT_MAX));
    n_directed = pending_pairs.size();
    repeat (N_RANDOM) pending_pairs.push_back(rand_pair());
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (pending_pairs.size() != 0 || start || expected_contacts.size() != 0)
      @(posedge clk);
    repeat (4 * LATENCY) @(posedge clk);
    if (errors == 0 && expected_contacts.size() == 0) begin
      $display("** aabb_pair_contact_points: PASSED **");
    end else begin
      $display("** aabb_pair_contact_points: FAILED **");
    end
    $finish;
  end

endmodule

### sim.f
src/abpc_pkg.sv
src/aabb_pair_contact_points.sv
bench/tb_aabb_pair_contact_points.sv
